/* rtl/rsas_pkg.sv */
`timescale 1ns / 1ps

package rsas_pkg;

  // Default sizing of the block.
  localparam int unsigned Channels   = 6;
  localparam int unsigned SampleBits = 16;

  // Fixed field widths of the request and result.
  localparam int unsigned SampleW  = 16;
  localparam int unsigned RelayW   = 6;
  localparam int unsigned ChanW    = 3;
  localparam int unsigned WaitW    = 16;
  localparam int unsigned LogW     = 2;
  localparam int unsigned CountW   = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegSettleTicks = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGapTicks    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegAverageLog2 = 2'd2;

  // Configuration reset values.
  localparam logic [WaitW-1:0] SettleTicksRst = 16'd100;
  localparam logic [WaitW-1:0] GapTicksRst    = 16'd1;
  localparam logic [LogW-1:0]  AverageLog2Rst = 2'd3;

  // Scan phases, one-hot.
  typedef enum logic [4:0] {
    PhSwitch = 5'b00001,
    PhSettle = 5'b00010,
    PhSample = 5'b00100,
    PhGap    = 5'b01000,
    PhEmit   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic               start_req;
    logic [SampleW-1:0] sample;
  } req_t;

  typedef struct packed {
    logic [RelayW-1:0]  relay_mask;
    logic               busy_res;
    logic               result_valid;
    logic [ChanW-1:0]   result_channel;
    logic [SampleW-1:0] result_value;
  } res_t;

  // Accumulator commands from the sequencer.
  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctl_t;

  // Sequencer status for the result of the current tick.
  typedef struct packed {
    logic [RelayW-1:0] relay_mask;
    logic              busy;
    logic              emit;
    logic [ChanW-1:0]  channel;
  } seq_status_t;

endpackage

/* rtl/rsas_acc.sv */
`timescale 1ns / 1ps

module rsas_acc #(
  parameter int unsigned SAMPLE_BITS = rsas_pkg::SampleBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              advance_i,
  input  rsas_pkg::acc_ctl_t                acc_ctl_i,
  input  logic [rsas_pkg::SampleW-1:0]      sample_i,
  input  logic [rsas_pkg::LogW-1:0]         average_log2_i,
  output logic [rsas_pkg::SampleW-1:0]      average_o
);

  localparam int unsigned AccW = SAMPLE_BITS + 3;
  localparam logic [rsas_pkg::SampleW-1:0] SampleMask =
    (SAMPLE_BITS >= rsas_pkg::SampleW) ? {rsas_pkg::SampleW{1'b1}}
                                       : rsas_pkg::SampleW'((32'd1 << SAMPLE_BITS) - 32'd1);

  logic [AccW-1:0] acc_q, acc_d;

  always_comb begin
    acc_d = acc_q;
    if (acc_ctl_i.clear) begin
      acc_d = '0;
    end else if (acc_ctl_i.add) begin
      acc_d = acc_q + AccW'(sample_i & SampleMask);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (advance_i) begin
      acc_q <= acc_d;
    end
  end

  // The emit tick reads the sum as left by the last sample.
  assign average_o = rsas_pkg::SampleW'(acc_q >> average_log2_i);

endmodule

/* rtl/rsas_ctrl.sv */
`timescale 1ns / 1ps

module rsas_ctrl #(
  parameter int unsigned CHANNELS = rsas_pkg::Channels
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  logic                          start_req_i,
  input  logic [rsas_pkg::WaitW-1:0]    settle_ticks_i,
  input  logic [rsas_pkg::WaitW-1:0]    gap_ticks_i,
  input  logic [rsas_pkg::LogW-1:0]     average_log2_i,
  output rsas_pkg::acc_ctl_t            acc_ctl_o,
  output rsas_pkg::seq_status_t         status_o
);

  rsas_pkg::phase_e                    phase_q, phase_d;
  logic [rsas_pkg::ChanW-1:0]          chan_q, chan_d;
  logic [rsas_pkg::CountW-1:0]         count_q, count_d;
  logic [rsas_pkg::WaitW-1:0]          wait_q, wait_d;
  logic                                run_q, run_d;
  logic [rsas_pkg::RelayW-1:0]         relay_q, relay_d;
  logic [(1 << rsas_pkg::ChanW)-1:0]   chan_onehot;
  logic [rsas_pkg::CountW-1:0]         count_inc;
  logic [rsas_pkg::CountW-1:0]         target;
  logic                                emit;
  logic                                in_range;

  assign chan_onehot = (1 << rsas_pkg::ChanW)'(1) << chan_q;
  assign count_inc   = count_q + rsas_pkg::CountW'(1);
  assign target      = rsas_pkg::CountW'(1) << average_log2_i;
  assign in_range    = {1'b0, chan_q} < (rsas_pkg::ChanW + 1)'(CHANNELS);

  always_comb begin
    phase_d   = phase_q;
    chan_d    = chan_q;
    count_d   = count_q;
    wait_d    = wait_q;
    run_d     = run_q | start_req_i;
    relay_d   = relay_q;
    emit      = 1'b0;
    acc_ctl_o = '0;
    if (run_d) begin
      if (in_range) begin
        case (phase_q)
          rsas_pkg::PhSettle: begin
            if (wait_q == '0) begin
              phase_d = rsas_pkg::PhSample;
            end else begin
              wait_d = wait_q - rsas_pkg::WaitW'(1);
            end
            count_d         = '0;
            acc_ctl_o.clear = 1'b1;
          end
          rsas_pkg::PhSample: begin
            acc_ctl_o.add = 1'b1;
            count_d       = count_inc;
            if (count_inc >= target) begin
              phase_d = rsas_pkg::PhEmit;
            end else begin
              wait_d  = gap_ticks_i;
              phase_d = rsas_pkg::PhGap;
            end
          end
          rsas_pkg::PhGap: begin
            if (wait_q == '0) begin
              phase_d = rsas_pkg::PhSample;
            end else begin
              wait_d = wait_q - rsas_pkg::WaitW'(1);
            end
          end
          rsas_pkg::PhEmit: begin
            emit    = 1'b1;
            chan_d  = chan_q + rsas_pkg::ChanW'(1);
            phase_d = rsas_pkg::PhSwitch;
          end
          default: begin
            relay_d = chan_onehot[rsas_pkg::RelayW-1:0];
            wait_d  = settle_ticks_i;
            count_d = '0;
            phase_d = rsas_pkg::PhSettle;
          end
        endcase
      end else begin
        chan_d = '0;
        run_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rsas_pkg::PhSwitch;
      chan_q  <= '0;
      count_q <= '0;
      wait_q  <= '0;
      run_q   <= 1'b0;
      relay_q <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      chan_q  <= chan_d;
      count_q <= count_d;
      wait_q  <= wait_d;
      run_q   <= run_d;
      relay_q <= relay_d;
    end
  end

  assign status_o.relay_mask = relay_d;
  assign status_o.busy       = run_d;
  assign status_o.emit       = emit;
  assign status_o.channel    = emit ? chan_q : '0;

endmodule

/* rtl/relay_scan_averaging_sequencer_unit.sv */
`timescale 1ns / 1ps

// Relay scan averaging sequencer. Every request is one poll tick carrying a
// start flag and the converter's current reading, and every request yields
// exactly one result in the cycle after it is accepted. A start request kicks
// off a scan over the channels in turn: the block drives a one-hot relay
// mask, waits settle_ticks + 1 ticks, then sums 2^average_log2 readings
// with gap_ticks + 1 ticks between successive readings and reports the sum
// shifted right by average_log2 together with the channel number. Busy drops
// one tick after the last channel has been reported, and the relay mask keeps
// its last value. The block takes one request per clock cycle; the figure is
// set by the single result register, which can be refilled in the same cycle
// it is drained, so throughput only falls when the downstream side stalls.
// There is no clearing pass after reset. Configuration registers are written
// through a separate port that is always ready and should only be written
// while no result is outstanding.
module relay_scan_averaging_sequencer_unit #(
  parameter int unsigned CHANNELS    = rsas_pkg::Channels,
  parameter int unsigned SAMPLE_BITS = rsas_pkg::SampleBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  rsas_pkg::req_t                    in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rsas_pkg::res_t                    out_res_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rsas_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rsas_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic [rsas_pkg::WaitW-1:0]   settle_q;
  logic [rsas_pkg::WaitW-1:0]   gap_q;
  logic [rsas_pkg::LogW-1:0]    log2_q;
  logic                         accept;
  logic                         cfg_write;
  rsas_pkg::acc_ctl_t           acc_ctl;
  rsas_pkg::seq_status_t        status;
  logic [rsas_pkg::SampleW-1:0] average;
  logic                         out_valid_q, out_valid_d;
  rsas_pkg::res_t               out_res_q, out_res_d;

  // The result register can take a new request whenever it is empty or is
  // being drained in this same cycle.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Configuration registers. Writes to an index past the list are ignored.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= rsas_pkg::SettleTicksRst;
      gap_q    <= rsas_pkg::GapTicksRst;
      log2_q   <= rsas_pkg::AverageLog2Rst;
    end else if (cfg_write) begin
      case (cfg_index_i)
        rsas_pkg::RegSettleTicks: settle_q <= cfg_data_i;
        rsas_pkg::RegGapTicks:    gap_q    <= cfg_data_i;
        rsas_pkg::RegAverageLog2: log2_q   <= cfg_data_i[rsas_pkg::LogW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Phase sequencer: channel, relay drive, counters and busy.
  rsas_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (accept),
    .start_req_i    (in_req_i.start_req),
    .settle_ticks_i (settle_q),
    .gap_ticks_i    (gap_q),
    .average_log2_i (log2_q),
    .acc_ctl_o      (acc_ctl),
    .status_o       (status)
  );

  // Sample accumulator and the averaging shift.
  rsas_acc #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_acc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (accept),
    .acc_ctl_i      (acc_ctl),
    .sample_i       (in_req_i.sample),
    .average_log2_i (log2_q),
    .average_o      (average)
  );

  // Assemble the result; value and channel read zero when nothing is emitted.
  always_comb begin
    out_res_d.relay_mask     = status.relay_mask;
    out_res_d.busy_res       = status.busy;
    out_res_d.result_valid   = status.emit;
    out_res_d.result_channel = status.channel;
    out_res_d.result_value   = status.emit ? average : '0;
  end

  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // The payload register needs no reset; it is only read while valid.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_res_q <= out_res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // An emitted average always belongs to a scan that is still running.
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.result_valid |-> out_res_o.busy_res)
    else $error("average emitted while not busy");

  // Channel and value are zero on ticks that emit nothing.
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.result_valid |->
      (out_res_o.result_channel == '0) && (out_res_o.result_value == '0))
    else $error("nonzero result fields without an emitted average");

  // At most one relay is ever driven.
  a_relay_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(out_res_o.relay_mask))
    else $error("more than one relay driven");

  // Every accepted request shows up as a result in the next cycle.
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted request produced no result");

endmodule
